// ----- design/ptat_ctat_temperature_calibration_assert.svh -----
// Assertion macros shared by the calibration block.
// Each check is sampled on clk and held off while arst_n is low.
`ifndef PTAT_CTAT_TEMPERATURE_CALIBRATION_ASSERT_SVH
`define PTAT_CTAT_TEMPERATURE_CALIBRATION_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define PTC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptc assertion failed")

// Next-cycle implication.
`define PTC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptc assertion failed")

`else

`define PTC_ASSERT_IMP(lbl, ante, cons)
`define PTC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- design/ptc_pkg.sv -----
`timescale 1ns / 1ps

package ptc_pkg;

	// Default converter reading width.
	localparam int SAMPLE_BITS_DEF = 12;

	// Calibration temperature width, tenths of a degree.
	localparam int TEMP_BITS = 12;

	// Quotient bits resolved by the divider; larger quotients are flagged.
	localparam int QUO_BITS = 32;

	// Configuration port index width.
	localparam int CFG_IDX_BITS = 3;

	// Clamp limits of the result.
	localparam logic signed [31:0] TEMP_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] TEMP_MIN = 32'sh8000_0000;

	// Configuration register map.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_LOW_TEMP  = 3'd0,
		REG_HIGH_TEMP = 3'd1,
		REG_PTAT_LOW  = 3'd2,
		REG_PTAT_HIGH = 3'd3,
		REG_CTAT_LOW  = 3'd4,
		REG_CTAT_HIGH = 3'd5
	} cfg_reg_t;

	// Side information that travels with a request through the divider.
	typedef struct packed {
		logic neg;   // numerator and denominator signs differ
		logic zero;  // denominator was zero
		logic ovf;   // quotient does not fit QUO_BITS
	} flags_t;

endpackage

// ----- design/ptc_divider.sv -----
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, most significant
// first. Overflow of the quotient width is detected in the first stage.
module ptc_divider #(
	parameter int REM_W = 41,
	parameter int DEN_W = 26
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [REM_W-1:0]                in_rem,
	input  logic [DEN_W-1:0]                in_den,
	input  ptc_pkg::flags_t                 in_flags,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ptc_pkg::QUO_BITS-1:0]    out_quo,
	output ptc_pkg::flags_t                 out_flags
);

	localparam int QB = ptc_pkg::QUO_BITS;

	logic                vld_s [1:QB];
	logic [REM_W-1:0]    rem_s [1:QB];
	logic [DEN_W-1:0]    den_s [1:QB];
	logic [QB-1:0]       quo_s [1:QB];
	ptc_pkg::flags_t     flg_s [1:QB];
	logic                rdy   [1:QB+1];

	assign rdy[QB+1] = out_ready;
	assign in_ready  = rdy[1];

	for (genvar j = 1; j <= QB; j++) begin : g_stage
		localparam int K = QB - j;

		logic             pv;
		logic [REM_W-1:0] pr;
		logic [DEN_W-1:0] py;
		logic [QB-1:0]    pq;
		ptc_pkg::flags_t  pf;
		logic             ge;
		logic [REM_W-1:0] nr;
		logic [QB-1:0]    nq;

		// Select the previous stage, or the input port for the first one.
		if (j == 1) begin : g_first
			assign pv = in_valid;
			assign pr = in_rem;
			assign py = in_den;
			assign pq = '0;
			assign pf = '{neg: in_flags.neg, zero: in_flags.zero,
				ovf: (in_rem >> QB) >= REM_W'(in_den)};
		end else begin : g_next
			assign pv = vld_s[j-1];
			assign pr = rem_s[j-1];
			assign py = den_s[j-1];
			assign pq = quo_s[j-1];
			assign pf = flg_s[j-1];
		end

		// Resolve quotient bit K: subtract the shifted divisor when it fits.
		always_comb begin
			ge = (pr >> K) >= REM_W'(py);
			nr = ge ? pr - (REM_W'(py) << K) : pr;
			nq = pq;
			nq[K] = ge;
		end

		assign rdy[j] = !vld_s[j] || rdy[j+1];

		// Advance the stage whenever the next one can take its request.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (rdy[j]) begin
				vld_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[j] && pv) begin
				rem_s[j] <= nr;
				den_s[j] <= py;
				quo_s[j] <= nq;
				flg_s[j] <= pf;
			end
		end
	end

	assign out_valid = vld_s[QB];
	assign out_quo   = quo_s[QB];
	assign out_flags = flg_s[QB];

endmodule

// ----- design/ptat_ctat_temperature_calibration.sv -----
`timescale 1ns / 1ps

// Two-point PTAT/CTAT temperature calibration. Each request carries one PTAT
// and one CTAT reading and yields one temperature in hundredths of a degree,
// rounded half away from zero, clamped to 32 bits with a saturation flag, and
// zero with valid_res low when the calibration gives a zero denominator. The
// pipeline takes one request per cycle while out_ready does not stall it, and
// each request passes through 37 register stages: four arithmetic stages
// (calibration products, numerator and denominator, magnitudes, scaled
// dividend), 32 divider stages that each resolve one quotient bit, and the
// output register. Each stage stalls only when it is full and the one after
// it is stalled, so bubbles close up under backpressure.
// Write the six calibration registers while no request is in flight.
module ptat_ctat_temperature_calibration #(
	parameter int SAMPLE_BITS = ptc_pkg::SAMPLE_BITS_DEF,
	localparam int CFG_DW = (ptc_pkg::TEMP_BITS > SAMPLE_BITS) ? ptc_pkg::TEMP_BITS : SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [SAMPLE_BITS-1:0]              ptat_sample,
	input  logic [SAMPLE_BITS-1:0]              ctat_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [31:0]                  temp_centi,
	output logic                                valid_res,
	output logic                                saturated,
	input  logic                                cfg_we,
	input  logic [ptc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [CFG_DW-1:0]                   cfg_data
);

	localparam int TW     = ptc_pkg::TEMP_BITS;
	localparam int S      = SAMPLE_BITS;
	localparam int PW     = TW + S;          // calibration product
	localparam int AW     = PW + 1;          // signed coefficient
	localparam int NW     = 2 * S + TW + 2;  // signed numerator
	localparam int DW     = 2 * S + 2;       // signed denominator
	localparam int XW     = NW + 5;          // dividend 20*|N| + |D|
	localparam int QB     = ptc_pkg::QUO_BITS;

	// Calibration registers.
	logic [TW-1:0] tl_q, th_q;
	logic [S-1:0]  vpl_q, vph_q, vcl_q, vch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q  <= '0;
			th_q  <= '0;
			vpl_q <= '0;
			vph_q <= '0;
			vcl_q <= '0;
			vch_q <= '0;
		end else if (cfg_we) begin
			unique case (ptc_pkg::cfg_reg_t'(cfg_index))
				ptc_pkg::REG_LOW_TEMP:  tl_q  <= cfg_data[TW-1:0];
				ptc_pkg::REG_HIGH_TEMP: th_q  <= cfg_data[TW-1:0];
				ptc_pkg::REG_PTAT_LOW:  vpl_q <= cfg_data[S-1:0];
				ptc_pkg::REG_PTAT_HIGH: vph_q <= cfg_data[S-1:0];
				ptc_pkg::REG_CTAT_LOW:  vcl_q <= cfg_data[S-1:0];
				ptc_pkg::REG_CTAT_HIGH: vch_q <= cfg_data[S-1:0];
				default: ;
			endcase
		end
	end

	// Stage handshake chain.
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_out;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic div_in_ready, div_out_valid;
	logic [QB-1:0] div_quo;
	ptc_pkg::flags_t div_flags;
	logic out_valid_q;

	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s4   = !vld_s4 || div_in_ready;
	assign rdy_out  = !out_valid_q || out_ready;
	assign in_ready = rdy_s1;

	// Stage 1: coefficients from the calibration, capture the readings.
	logic [PW-1:0]        p_tl_vph, p_th_vpl, p_th_vcl, p_tl_vch;
	logic signed [AW-1:0] coef_a, coef_b;
	logic signed [S:0]    dif_p, dif_c;
	logic [S-1:0]         tp_s1, tc_s1;
	logic signed [AW-1:0] a_s1, b_s1;
	logic signed [S:0]    dp_s1, dc_s1;

	always_comb begin
		p_tl_vph = PW'(tl_q) * PW'(vph_q);
		p_th_vpl = PW'(th_q) * PW'(vpl_q);
		p_th_vcl = PW'(th_q) * PW'(vcl_q);
		p_tl_vch = PW'(tl_q) * PW'(vch_q);
		coef_a   = $signed({1'b0, p_tl_vph}) - $signed({1'b0, p_th_vpl});
		coef_b   = $signed({1'b0, p_th_vcl}) - $signed({1'b0, p_tl_vch});
		dif_p    = $signed({1'b0, vcl_q}) - $signed({1'b0, vch_q});
		dif_c    = $signed({1'b0, vph_q}) - $signed({1'b0, vpl_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			tp_s1 <= ptat_sample;
			tc_s1 <= ctat_sample;
			a_s1  <= coef_a;
			b_s1  <= coef_b;
			dp_s1 <= dif_p;
			dc_s1 <= dif_c;
		end
	end

	// Stage 2: numerator and denominator.
	logic signed [NW-1:0] n_tc, n_tp, num_c;
	logic signed [DW-1:0] d_tp, d_tc, den_c;
	logic signed [NW-1:0] num_s2;
	logic signed [DW-1:0] den_s2;

	always_comb begin
		n_tc  = NW'($signed({1'b0, tc_s1})) * NW'(a_s1);
		n_tp  = NW'($signed({1'b0, tp_s1})) * NW'(b_s1);
		num_c = n_tc + n_tp;
		d_tp  = DW'($signed({1'b0, tp_s1})) * DW'(dp_s1);
		d_tc  = DW'($signed({1'b0, tc_s1})) * DW'(dc_s1);
		den_c = d_tp + d_tc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			num_s2 <= num_c;
			den_s2 <= den_c;
		end
	end

	// Stage 3: magnitudes and sign of the quotient.
	logic [NW-1:0]   nm_s3;
	logic [DW-1:0]   dm_s3;
	ptc_pkg::flags_t flg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			nm_s3       <= num_s2[NW-1] ? NW'(-num_s2) : NW'(num_s2);
			dm_s3       <= den_s2[DW-1] ? DW'(-den_s2) : DW'(den_s2);
			flg_s3.neg  <= num_s2[NW-1] ^ den_s2[DW-1];
			flg_s3.zero <= (den_s2 == '0);
			flg_s3.ovf  <= 1'b0;
		end
	end

	// Stage 4: rounding dividend 20*|N| + |D| over divisor 2*|D|.
	logic [XW-1:0]   x_s4;
	logic [DW-1:0]   y_s4;
	ptc_pkg::flags_t flg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (rdy_s4) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			x_s4   <= (XW'(nm_s3) << 4) + (XW'(nm_s3) << 2) + XW'(dm_s3);
			y_s4   <= dm_s3 << 1;
			flg_s4 <= flg_s3;
		end
	end

	// Quotient, one bit per stage.
	ptc_divider #(
		.REM_W (XW),
		.DEN_W (DW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.in_ready  (div_in_ready),
		.in_rem    (x_s4),
		.in_den    (y_s4),
		.in_flags  (flg_s4),
		.out_valid (div_out_valid),
		.out_ready (rdy_out),
		.out_quo   (div_quo),
		.out_flags (div_flags)
	);

	// Apply the sign, clamp, and drop invalid results to zero.
	logic signed [31:0] res_temp;
	logic               res_sat;
	logic signed [31:0] temp_q;
	logic               vres_q, sat_q;

	always_comb begin
		res_sat = 1'b0;
		priority if (div_flags.zero) begin
			res_temp = '0;
		end else if (div_flags.neg && (div_flags.ovf || div_quo != '0)) begin
			if (div_flags.ovf || div_quo > 32'h8000_0000) begin
				res_temp = ptc_pkg::TEMP_MIN;
				res_sat  = 1'b1;
			end else begin
				res_temp = $signed(32'd0 - div_quo);
			end
		end else begin
			if (div_flags.ovf || div_quo[QB-1]) begin
				res_temp = ptc_pkg::TEMP_MAX;
				res_sat  = 1'b1;
			end else begin
				res_temp = $signed(div_quo);
			end
		end
	end

	// Output register: hold the result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && div_out_valid) begin
			temp_q <= res_temp;
			vres_q <= !div_flags.zero;
			sat_q  <= res_sat;
		end
	end

	assign out_valid  = out_valid_q;
	assign temp_centi = temp_q;
	assign valid_res  = vres_q;
	assign saturated  = sat_q;

	`include "ptat_ctat_temperature_calibration_assert.svh"

	// A full pipeline means the result side is stalled.
	`PTC_ASSERT_IMP(a_ready_low_only_when_stalled, !in_ready, out_valid && !out_ready);
	// An unusable result carries zero and no saturation.
	`PTC_ASSERT_IMP(a_invalid_is_zero, out_valid && !valid_res,
		temp_centi == '0 && !saturated);
	// A saturated result sits at one of the clamp limits.
	`PTC_ASSERT_IMP(a_sat_at_limit, out_valid && saturated,
		temp_centi == ptc_pkg::TEMP_MAX || temp_centi == ptc_pkg::TEMP_MIN);
	// A request taken by the first stage makes it full next cycle.
	`PTC_ASSERT_NXT(a_accept_fills, in_valid && in_ready, vld_s1);

endmodule
